FILE: rtl/indexed_list_stack_assert.svh
// Assertion macros for the indexed list stack RTL.
// Used by rtl/indexed_list_stack.sv; expects clk_i and rst_ni in scope.
`ifndef INDEXED_LIST_STACK_ASSERT_SVH
`define INDEXED_LIST_STACK_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ILS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("indexed_list_stack: same-cycle check failed");
`define ILS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("indexed_list_stack: next-cycle check failed");
`else
`define ILS_ASSERT_IMPLY(lbl, ante, cons)
`define ILS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/ils_pkg.sv
// Package for the indexed list stack: operation and status codes,
// request and response item types, default capacity. No dependencies.
package ils_pkg;

  localparam int DefCapacity = 16;
  localparam int KindW       = 3;
  localparam int PosW        = 5;
  localparam int DataW       = 32;
  localparam int StatusW     = 2;
  localparam int CountW      = 5;

  typedef enum logic [KindW-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_PEEK   = 3'd2,
    KIND_GET    = 3'd3,
    KIND_SET    = 3'd4,
    KIND_INSERT = 3'd5,
    KIND_REMOVE = 3'd6
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [KindW-1:0]        kind;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] data_out;
    logic [StatusW-1:0]      status;
    logic [CountW-1:0]       count;
  } rsp_t;

endpackage

FILE: rtl/indexed_list_stack.sv
// Indexed list stack: bounded list of signed words with stack and indexed ops.
// Depends on rtl/ils_pkg.sv and rtl/indexed_list_stack_assert.svh.
//
//   channel   | handshake         | payload          | direction
//   ----------+-------------------+------------------+----------
//   request   | start_i / busy_o  | req_i (req_t)    | in
//   response  | done_o strobe     | rsp_o (rsp_t)    | out
//
// One item is taken every cycle; busy_o stays low.
// The response strobes once the item has passed the request register, then the
// read mux and per-cell shift network into the response register.
// That shift network, where every cell loads, holds or takes a neighbor in
// parallel, updates all cells of the list together.
// Reset clears the count and the valid flags; entry cells are not reset.
// The receiver cannot stall; every strobed response must be taken.

`include "indexed_list_stack_assert.svh"

module indexed_list_stack #(
  parameter int CAPACITY = ils_pkg::DefCapacity
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  ils_pkg::req_t req_i,
  output logic          done_o,
  output ils_pkg::rsp_t rsp_o
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > ils_pkg::PosW) ? CW : ils_pkg::PosW) + 1;

  logic                                valid_q;
  ils_pkg::req_t                       req_q;
  logic [CW-1:0]                       count_q, count_d;
  logic signed [ils_pkg::DataW-1:0]    cells_q [CAPACITY];
  logic signed [ils_pkg::DataW-1:0]    cells_d [CAPACITY];
  logic                                done_q;
  ils_pkg::rsp_t                       rsp_q, rsp_d;

  logic [CMPW-1:0]                     cnt_ext, pos_ext, rd_sel;
  logic                                empty, full, pos_in, pos_ins_ok;
  logic                                wr_push, wr_set, wr_ins, wr_rem;
  logic signed [ils_pkg::DataW-1:0]    rd_data, data_d;
  ils_pkg::status_e                    status_d;

  assign busy_o = 1'b0;

  // Request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
  end

  assign cnt_ext    = CMPW'(count_q);
  assign pos_ext    = CMPW'(req_q.position);
  assign empty      = (count_q == '0);
  assign full       = (count_q == CW'(CAPACITY));
  assign pos_in     = (pos_ext < cnt_ext);
  assign pos_ins_ok = (pos_ext <= cnt_ext);

  // Pop and peek read the last entry; indexed operations read at position.
  assign rd_sel = ((req_q.kind == ils_pkg::KIND_POP) || (req_q.kind == ils_pkg::KIND_PEEK))
                  ? (cnt_ext - CMPW'(1)) : pos_ext;

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_sel == CMPW'(i)) begin
        rd_data = cells_q[i];
      end
    end
  end

  always_comb begin
    wr_push  = 1'b0;
    wr_set   = 1'b0;
    wr_ins   = 1'b0;
    wr_rem   = 1'b0;
    data_d   = '0;
    status_d = ils_pkg::ST_OK;
    count_d  = count_q;
    unique case (req_q.kind)
      ils_pkg::KIND_PUSH: begin
        if (full) begin
          status_d = ils_pkg::ST_FULL;
        end else begin
          wr_push = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      ils_pkg::KIND_POP: begin
        if (empty) begin
          status_d = ils_pkg::ST_EMPTY;
        end else begin
          data_d  = rd_data;
          count_d = count_q - CW'(1);
        end
      end
      ils_pkg::KIND_PEEK: begin
        if (empty) begin
          status_d = ils_pkg::ST_EMPTY;
        end else begin
          data_d = rd_data;
        end
      end
      ils_pkg::KIND_GET: begin
        if (empty) begin
          status_d = ils_pkg::ST_EMPTY;
        end else if (!pos_in) begin
          status_d = ils_pkg::ST_RANGE;
        end else begin
          data_d = rd_data;
        end
      end
      ils_pkg::KIND_SET: begin
        if (empty) begin
          status_d = ils_pkg::ST_EMPTY;
        end else if (!pos_in) begin
          status_d = ils_pkg::ST_RANGE;
        end else begin
          wr_set = 1'b1;
        end
      end
      ils_pkg::KIND_INSERT: begin
        // The range check takes precedence over the full check.
        if (!pos_ins_ok) begin
          status_d = ils_pkg::ST_RANGE;
        end else if (full) begin
          status_d = ils_pkg::ST_FULL;
        end else begin
          wr_ins  = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      ils_pkg::KIND_REMOVE: begin
        if (empty) begin
          status_d = ils_pkg::ST_EMPTY;
        end else if (!pos_in) begin
          status_d = ils_pkg::ST_RANGE;
        end else begin
          wr_rem  = 1'b1;
          data_d  = rd_data;
          count_d = count_q - CW'(1);
        end
      end
      default: begin
        // The unused code leaves the list alone and reports success.
      end
    endcase
  end

  // Each cell loads the new value, takes its lower or upper neighbor, or holds.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [ils_pkg::DataW-1:0] lower, upper;
    logic [CMPW-1:0]                  idx;

    assign idx = CMPW'(g);

    if (g == 0) begin : g_first
      assign lower = cells_q[g];
    end else begin : g_mid
      assign lower = cells_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign upper = cells_q[g];
    end else begin : g_below
      assign upper = cells_q[g+1];
    end

    always_comb begin
      cells_d[g] = cells_q[g];
      if ((wr_push && (idx == cnt_ext)) || (wr_set && (idx == pos_ext)) ||
          (wr_ins && (idx == pos_ext))) begin
        cells_d[g] = req_q.data_in;
      end else if (wr_ins && (idx > pos_ext) && (idx <= cnt_ext)) begin
        cells_d[g] = lower;
      end else if (wr_rem && (idx >= pos_ext) && ((idx + CMPW'(1)) < cnt_ext)) begin
        cells_d[g] = upper;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      cells_q <= cells_d;
    end
  end

  assign rsp_d.data_out = data_d;
  assign rsp_d.status   = status_d;
  assign rsp_d.count    = ils_pkg::CountW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= valid_q;
      if (valid_q) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `ILS_ASSERT_NEXT(a_load, start_i && !busy_o, valid_q)
  `ILS_ASSERT_NEXT(a_strobe, valid_q, done_q)
  `ILS_ASSERT_NEXT(a_fail_holds, valid_q && (status_d != ils_pkg::ST_OK), count_q == $past(count_q))
  `ILS_ASSERT_NEXT(a_idle_holds, !valid_q, count_q == $past(count_q))
  `ILS_ASSERT_IMPLY(a_bound, done_q, count_q <= CW'(CAPACITY))

endmodule

FILE: tb/indexed_list_stack_tb.sv
// Self-checking testbench for the indexed list stack: directed and random operations
// with a predictor of the list contents and a per-field check of every response.
// Depends on rtl/ils_pkg.sv and rtl/indexed_list_stack.sv.
module indexed_list_stack_tb;

  localparam int Cap = ils_pkg::DefCapacity;
  localparam int StallLimit = 2000;
  localparam int DrainCycles = 8;
  localparam int RandomItems = 650;
  localparam logic [ils_pkg::KindW-1:0] KindUnused = 3'd7;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  ils_pkg::req_t  req_i = '0;
  logic           busy_o;
  logic           done_o;
  ils_pkg::rsp_t  rsp_o;

  indexed_list_stack #(.CAPACITY(Cap)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Items waiting to be driven, and responses the list is expected to return.
  ils_pkg::req_t op_queue[$];
  ils_pkg::rsp_t rsp_due[$];
  logic [31:0]   list_cells[Cap];
  int unsigned   list_len = 0;
  int            err_count = 0;
  int            stall_cycles = 0;
  int            gap_left = 0;
  bit            burst_mode = 1'b0;

  task automatic note_error(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  // Applies one operation to the predicted list and returns the response it implies.
  function automatic ils_pkg::rsp_t apply_list_op(input ils_pkg::req_t r);
    ils_pkg::rsp_t o;
    int unsigned   pos;
    o = '0;
    o.status = ils_pkg::ST_OK;
    pos = 32'(r.position);
    unique case (r.kind)
      ils_pkg::KIND_PUSH: begin
        if (list_len >= Cap) begin
          o.status = ils_pkg::ST_FULL;
        end else begin
          list_cells[list_len] = r.data_in;
          list_len++;
        end
      end
      ils_pkg::KIND_POP: begin
        if (list_len == 0) begin
          o.status = ils_pkg::ST_EMPTY;
        end else begin
          list_len--;
          o.data_out = list_cells[list_len];
        end
      end
      ils_pkg::KIND_PEEK: begin
        if (list_len == 0) o.status = ils_pkg::ST_EMPTY;
        else o.data_out = list_cells[list_len-1];
      end
      ils_pkg::KIND_GET: begin
        if (list_len == 0) o.status = ils_pkg::ST_EMPTY;
        else if (pos >= list_len) o.status = ils_pkg::ST_RANGE;
        else o.data_out = list_cells[pos];
      end
      ils_pkg::KIND_SET: begin
        if (list_len == 0) o.status = ils_pkg::ST_EMPTY;
        else if (pos >= list_len) o.status = ils_pkg::ST_RANGE;
        else list_cells[pos] = r.data_in;
      end
      ils_pkg::KIND_INSERT: begin
        // The range check wins over the full check.
        if (pos > list_len) begin
          o.status = ils_pkg::ST_RANGE;
        end else if (list_len >= Cap) begin
          o.status = ils_pkg::ST_FULL;
        end else begin
          for (int i = list_len; i > pos; i--) list_cells[i] = list_cells[i-1];
          list_cells[pos] = r.data_in;
          list_len++;
        end
      end
      ils_pkg::KIND_REMOVE: begin
        if (list_len == 0) begin
          o.status = ils_pkg::ST_EMPTY;
        end else if (pos >= list_len) begin
          o.status = ils_pkg::ST_RANGE;
        end else begin
          o.data_out = list_cells[pos];
          for (int i = pos; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      default: begin
      end
    endcase
    o.count = list_len[ils_pkg::CountW-1:0];
    return o;
  endfunction

  function automatic int pick_gap();
    int roll;
    if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
    if (burst_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [ils_pkg::DataW-1:0] rand_word();
    unique case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_item(input logic [ils_pkg::KindW-1:0] kind, input int pos,
                            input logic [ils_pkg::DataW-1:0] data);
    ils_pkg::req_t r;
    r.kind = kind;
    r.position = pos[ils_pkg::PosW-1:0];
    r.data_in = data;
    op_queue.push_back(r);
  endtask

  // Driver: one item per accepting edge, with random gaps between items.
  always @(posedge clk_i) begin
    logic took;
    if (rst_ni) begin
      took = start_i && !busy_o;
      if (took) rsp_due.push_back(apply_list_op(req_i));
      if (!start_i || took) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (op_queue.size() > 0) begin
          start_i <= 1'b1;
          req_i <= op_queue.pop_front();
          gap_left = pick_gap();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed response is checked against the oldest prediction.
  always @(posedge clk_i) begin
    ils_pkg::rsp_t want;
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) stall_cycles = 0;
      else stall_cycles++;
      if (done_o) begin
        if (rsp_due.size() == 0) begin
          note_error($sformatf("response with nothing expected: %h", rsp_o));
        end else begin
          want = rsp_due.pop_front();
          if (rsp_o.data_out !== want.data_out)
            note_error($sformatf("data_out %h, want %h", rsp_o.data_out, want.data_out));
          if (rsp_o.status !== want.status)
            note_error($sformatf("status %0d, want %0d", rsp_o.status, want.status));
          if (rsp_o.count !== want.count)
            note_error($sformatf("count %0d, want %0d", rsp_o.count, want.count));
        end
      end
    end else begin
      stall_cycles++;
    end
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("[indexed_list_stack] ERROR");
    $finish;
  end

  initial begin
    phase_e phase;
    int     phase_left;
    int     roll;
    int     pos;

    // Directed part, written against a list that starts empty.
    queue_item(ils_pkg::KIND_POP, 0, 32'h1234_5678);
    queue_item(ils_pkg::KIND_PEEK, 0, 0);
    queue_item(ils_pkg::KIND_GET, 0, 0);
    queue_item(ils_pkg::KIND_SET, 0, 32'hdead_beef);
    queue_item(ils_pkg::KIND_REMOVE, 0, 0);
    queue_item(ils_pkg::KIND_INSERT, 1, 32'h1111_1111);
    queue_item(KindUnused, 31, 32'hffff_ffff);
    queue_item(ils_pkg::KIND_PUSH, 0, 32'h7fff_ffff);
    queue_item(ils_pkg::KIND_PUSH, 31, 32'h8000_0000);
    queue_item(ils_pkg::KIND_INSERT, 0, 32'hffff_ffff);
    // Inserting at the current count appends at the back.
    queue_item(ils_pkg::KIND_INSERT, 3, 32'h0000_0000);
    queue_item(ils_pkg::KIND_INSERT, 5, 32'h2222_2222);
    queue_item(ils_pkg::KIND_GET, 31, 0);
    queue_item(ils_pkg::KIND_GET, 16, 0);
    queue_item(ils_pkg::KIND_SET, 1, 32'h5555_5555);
    queue_item(ils_pkg::KIND_GET, 1, 0);
    queue_item(ils_pkg::KIND_REMOVE, 0, 0);
    queue_item(ils_pkg::KIND_REMOVE, 3, 0);
    queue_item(ils_pkg::KIND_REMOVE, 2, 0);
    queue_item(ils_pkg::KIND_PEEK, 0, 0);
    queue_item(ils_pkg::KIND_POP, 0, 0);
    queue_item(ils_pkg::KIND_POP, 0, 0);
    queue_item(ils_pkg::KIND_POP, 0, 0);
    queue_item(KindUnused, 0, 32'haaaa_aaaa);

    // Random part in phases that fill the list toward full, drain it, or mix.
    phase = PH_FILL;
    phase_left = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (phase_left == 0) begin
        phase = phase_e'($urandom_range(0, 2));
        phase_left = $urandom_range(10, 30);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      pos = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
      unique case (phase)
        PH_FILL: begin
          if (roll < 60) begin
            queue_item(ils_pkg::KIND_PUSH, pos, rand_word());
          end else if (roll < 90) begin
            queue_item(ils_pkg::KIND_INSERT, $urandom_range(0, 8), rand_word());
          end else begin
            queue_item(ils_pkg::KindW'($urandom_range(0, 7)), pos, rand_word());
          end
        end
        PH_DRAIN: begin
          if (roll < 40) begin
            queue_item(ils_pkg::KIND_POP, pos, rand_word());
          end else if (roll < 80) begin
            queue_item(ils_pkg::KIND_REMOVE, $urandom_range(0, 6), rand_word());
          end else begin
            queue_item(ils_pkg::KindW'($urandom_range(0, 7)), pos, rand_word());
          end
        end
        default: begin
          queue_item(ils_pkg::KindW'($urandom_range(0, 7)), pos, rand_word());
        end
      endcase
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (op_queue.size() != 0 || start_i || rsp_due.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (err_count == 0) begin
      $display("[indexed_list_stack] OK");
    end else begin
      $display("[indexed_list_stack] ERROR");
    end
    $finish;
  end

endmodule
